FILE: src/lpf_pkg.sv
// Shared types and constants for the lipid pair Lennard-Jones force core.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package lpf_pkg;

	// Saturation value of the unsigned Q32.32 intermediate results
	localparam logic [63:0] QMax = 64'hFFFF_FFFF_FFFF_FFFF;
	// Largest value that can still be multiplied by twelve without overflow
	localparam logic [63:0] M12Lim = QMax / 64'd12;
	// Largest force magnitude per axis, 1.0 * 2^15 in Q16.16
	localparam logic [63:0] FMax = 64'h0000_0000_8000_0000;

	// Divider: two quotient bits per stage, 64 quotient bits
	localparam int DivSteps  = 2;
	localparam int DivStages = 64 / DivSteps;

	// Bead codes inside one lipid
	localparam logic [1:0] BeadHead = 2'd0;
	localparam logic [1:0] BeadMid  = 2'd1;
	localparam logic [1:0] BeadTail = 2'd2;

	// Register indexes
	localparam logic [2:0] RegBeadOffset = 3'd0;
	localparam logic [2:0] RegCutoff     = 3'd1;
	localparam logic [2:0] RegEpsHH      = 3'd2;
	localparam logic [2:0] RegRminHH     = 3'd3;
	localparam logic [2:0] RegEpsHT      = 3'd4;
	localparam logic [2:0] RegRminHT     = 3'd5;
	localparam logic [2:0] RegEpsTT      = 3'd6;
	localparam logic [2:0] RegRminTT     = 3'd7;

	// Configuration register file
	typedef struct packed {
		logic [30:0] bead_offset;
		logic [30:0] cutoff_radius;
		logic [30:0] eps_head_head;
		logic [30:0] rmin_head_head;
		logic [30:0] eps_head_tail;
		logic [30:0] rmin_head_tail;
		logic [30:0] eps_tail_tail;
		logic [30:0] rmin_tail_tail;
	} cfg_t;

	// Context of one bead pair as it travels down the force pipeline
	typedef struct packed {
		logic            vld;
		logic            skip;
		logic [1:0]      bead;
		logic            last;
		logic [2:0][31:0] mag;
		logic [2:0]      dneg;
		logic            neg;
		logic [30:0]     eps;
		logic [63:0]     r2;
		logic [63:0]     aux;
	} ctx_t;

endpackage

FILE: src/lpf_mulq.sv
// Two-stage saturating Q32.32 multiplier: min(floor(a*b / 2^32), 2^64-1).
// Carries a pair context alongside; depends on lpf_pkg.
`timescale 1ns / 1ps

module lpf_mulq import lpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  ctx_t        ctx_i,
	output logic [63:0] p,
	output ctx_t        ctx_o
);

	logic [63:0] hh_s1, hl_s1, lh_s1, ll_s1;
	ctx_t        ctx_s1;
	logic [96:0] sum;

	// Partial products of the 32-bit halves
	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1 <= 64'(a[63:32]) * 64'(b[63:32]);
			hl_s1 <= 64'(a[63:32]) * 64'(b[31:0]);
			lh_s1 <= 64'(a[31:0]) * 64'(b[63:32]);
			ll_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
		end
	end

	// Add the partial products aligned to Q32.32
	assign sum = 97'({hh_s1, 32'd0}) + 97'(hl_s1) + 97'(lh_s1) + 97'(ll_s1[63:32]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_s1 <= '0;
			ctx_o  <= '0;
		end else if (en) begin
			ctx_s1 <= ctx_i;
			ctx_o  <= ctx_s1;
		end
	end

	// Saturate on any carry above 64 bits
	always_ff @(posedge clk) begin
		if (en) begin
			p <= (|sum[96:64]) ? QMax : sum[63:0];
		end
	end

endmodule

FILE: src/lpf_div.sv
// Pipelined saturating Q32.32 divider: min(floor(num*2^32 / r2), 2^64-1),
// two quotient bits per stage; the divisor travels in the context. Uses lpf_pkg.
`timescale 1ns / 1ps

module lpf_div import lpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [63:0] num,
	input  ctx_t        ctx_i,
	output logic [63:0] q,
	output ctx_t        ctx_o
);

	logic [63:0] rem_q  [0:DivStages];
	logic [63:0] bits_q [0:DivStages];
	logic [63:0] quo_q  [0:DivStages];
	logic        sat_q  [0:DivStages];
	ctx_t        ctx_q  [0:DivStages];

	// Load: quotient overflows when num >= r2 * 2^32
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= 64'(num[63:32]);
			bits_q[0] <= {num[31:0], 32'd0};
			quo_q[0]  <= '0;
			sat_q[0]  <= {32'd0, num} >= {ctx_i.r2, 32'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q[0] <= '0;
		end else if (en) begin
			ctx_q[0] <= ctx_i;
		end
	end

	for (genvar k = 0; k < DivStages; k++) begin : g_stage
		logic [63:0] rem_n;
		logic [63:0] bits_n;
		logic [63:0] quo_n;

		// Restoring division steps
		always_comb begin
			logic [64:0] r;
			rem_n  = rem_q[k];
			bits_n = bits_q[k];
			quo_n  = quo_q[k];
			for (int s = 0; s < DivSteps; s++) begin
				r      = {rem_n, bits_n[63]};
				bits_n = {bits_n[62:0], 1'b0};
				if (r >= {1'b0, ctx_q[k].r2}) begin
					r     = r - {1'b0, ctx_q[k].r2};
					quo_n = {quo_n[62:0], 1'b1};
				end else begin
					quo_n = {quo_n[62:0], 1'b0};
				end
				rem_n = r[63:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1]  <= rem_n;
				bits_q[k+1] <= bits_n;
				quo_q[k+1]  <= quo_n;
				sat_q[k+1]  <= sat_q[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctx_q[k+1] <= '0;
			end else if (en) begin
				ctx_q[k+1] <= ctx_q[k];
			end
		end
	end

	assign q     = sat_q[DivStages] ? QMax : quo_q[DivStages];
	assign ctx_o = ctx_q[DivStages];

endmodule

FILE: src/lpf_seq.sv
// Pair sequencer: holds one lipid pair, places the beads and issues the nine
// bead pairs with distance vectors, one per cycle if enabled. Uses lpf_pkg.
`timescale 1ns / 1ps

module lpf_seq import lpf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  cfg_t         cfg,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [303:0] s_tdata,
	output ctx_t         ctx_o
);

	logic signed [31:0] apos_q [3];
	logic signed [33:0] aoff_q [3];
	logic signed [31:0] bpos_q [3];
	logic signed [33:0] boff_q [3];
	logic               hold_q;
	logic [1:0]         i_q, j_q;
	logic               last_pair, take;

	function automatic logic signed [33:0] scale_off(input logic signed [17:0] dir,
		input logic [30:0] off);
		logic [17:0] am;
		logic [48:0] pr;
		logic [32:0] rd;
		am = dir[17] ? 18'(-dir) : 18'(dir);
		pr = 49'(am) * 49'(off);
		rd = 33'((pr + 49'd32768) >> 16);
		return dir[17] ? -$signed({1'b0, rd}) : $signed({1'b0, rd});
	endfunction

	function automatic logic signed [34:0] place(input logic signed [31:0] pos,
		input logic signed [33:0] off, input logic [1:0] bead);
		logic signed [34:0] c;
		unique case (bead)
			BeadHead: c = 35'(pos) + 35'(off);
			BeadTail: c = 35'(pos) - 35'(off);
			default:  c = 35'(pos);
		endcase
		return c;
	endfunction

	assign last_pair = (i_q == BeadTail) && (j_q == BeadTail);
	assign s_tready  = !hold_q || (en && last_pair);
	assign take      = s_tvalid && s_tready;

	// Capture a new lipid pair and scale its directions
	always_ff @(posedge clk) begin
		if (take) begin
			for (int ax = 0; ax < 3; ax++) begin
				apos_q[ax] <= s_tdata[32*ax +: 32];
				aoff_q[ax] <= scale_off(s_tdata[96 + 18*ax +: 18], cfg.bead_offset);
				bpos_q[ax] <= s_tdata[150 + 32*ax +: 32];
				boff_q[ax] <= scale_off(s_tdata[246 + 18*ax +: 18], cfg.bead_offset);
			end
		end
	end

	// Step through the nine bead pairs, first lipid bead major
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			i_q    <= BeadHead;
			j_q    <= BeadHead;
		end else if (take) begin
			hold_q <= 1'b1;
			i_q    <= BeadHead;
			j_q    <= BeadHead;
		end else if (en && hold_q) begin
			if (last_pair) begin
				hold_q <= 1'b0;
			end
			if (j_q == BeadTail) begin
				j_q <= BeadHead;
				i_q <= (i_q == BeadTail) ? BeadHead : i_q + 2'd1;
			end else begin
				j_q <= j_q + 2'd1;
			end
		end
	end

	// Distance vector, cutoff box test and parameter pick
	ctx_t ctx_n;
	always_comb begin
		logic signed [35:0] d;
		logic [35:0]        m;
		logic               far;
		ctx_n      = '0;
		ctx_n.vld  = hold_q;
		ctx_n.bead = i_q;
		ctx_n.last = last_pair;
		far        = 1'b0;
		for (int ax = 0; ax < 3; ax++) begin
			d = 36'(place(apos_q[ax], aoff_q[ax], i_q)) -
				36'(place(bpos_q[ax], boff_q[ax], j_q));
			m = d[35] ? 36'(-d) : 36'(d);
			if (m > 36'(cfg.cutoff_radius)) begin
				far = 1'b1;
			end
			ctx_n.mag[ax]  = m[31:0];
			ctx_n.dneg[ax] = d[35];
		end
		ctx_n.skip = far;
		if (i_q == BeadHead && j_q == BeadHead) begin
			ctx_n.eps = cfg.eps_head_head;
			ctx_n.aux = 64'(cfg.rmin_head_head);
		end else if (i_q == BeadHead || j_q == BeadHead) begin
			ctx_n.eps = cfg.eps_head_tail;
			ctx_n.aux = 64'(cfg.rmin_head_tail);
		end else begin
			ctx_n.eps = cfg.eps_tail_tail;
			ctx_n.aux = 64'(cfg.rmin_tail_tail);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_o <= '0;
		end else if (en) begin
			ctx_o <= ctx_n;
		end
	end

endmodule

FILE: src/lpf_pair.sv
// Bead pair force pipeline: r^2, (rm^2/r^2)^3 and ^6, the Lennard-Jones
// factor and per-axis force magnitudes. Uses lpf_pkg, lpf_div and lpf_mulq.
`timescale 1ns / 1ps

module lpf_pair import lpf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  cfg_t            cfg,
	input  ctx_t            ctx_i,
	output logic [2:0][63:0] f,
	output ctx_t            ctx_o
);

	logic [63:0] sq_s2 [3];
	logic [63:0] rm2_s2, cut2_s2, rm2_s3;
	ctx_t        ctx_s2, ctx_s3, ctx_s3_n;
	logic [63:0] r2_sum;

	// Squares of distance components, rm and cutoff
	always_ff @(posedge clk) begin
		if (en) begin
			for (int ax = 0; ax < 3; ax++) begin
				sq_s2[ax] <= 64'(ctx_i.mag[ax]) * 64'(ctx_i.mag[ax]);
			end
			rm2_s2  <= 64'(ctx_i.aux[30:0]) * 64'(ctx_i.aux[30:0]);
			cut2_s2 <= 64'(cfg.cutoff_radius) * 64'(cfg.cutoff_radius);
			rm2_s3  <= rm2_s2;
		end
	end

	assign r2_sum = sq_s2[0] + sq_s2[1] + sq_s2[2];

	// Sum r^2 and drop coincident or far pairs
	always_comb begin
		ctx_s3_n      = ctx_s2;
		ctx_s3_n.r2   = r2_sum;
		ctx_s3_n.skip = ctx_s2.skip || (r2_sum == 64'd0) || (r2_sum > cut2_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_s2 <= '0;
			ctx_s3 <= '0;
		end else if (en) begin
			ctx_s2 <= ctx_i;
			ctx_s3 <= ctx_s3_n;
		end
	end

	// s = rm^2 / r^2
	logic [63:0] s, s2, s3, s6, m, g;
	ctx_t        cd1, cm1_i, cm1, cm2, cm3_i, cm3, cm4, cd2;
	ctx_t        ctx_e, ctx_e_n, ctx_12;
	logic [63:0] num12;

	lpf_div u_div_s (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(rm2_s3), .ctx_i(ctx_s3), .q(s), .ctx_o(cd1)
	);

	always_comb begin
		cm1_i     = cd1;
		cm1_i.aux = s;
	end

	lpf_mulq u_mul_s2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a(s), .b(s), .ctx_i(cm1_i), .p(s2), .ctx_o(cm1)
	);

	lpf_mulq u_mul_s3 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a(s2), .b(cm1.aux), .ctx_i(cm1), .p(s3), .ctx_o(cm2)
	);

	always_comb begin
		cm3_i     = cm2;
		cm3_i.aux = s3;
	end

	lpf_mulq u_mul_s6 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a(s3), .b(s3), .ctx_i(cm3_i), .p(s6), .ctx_o(cm3)
	);

	// e = s6 - s3 as sign and magnitude, saturated sixth power stays positive
	always_comb begin
		ctx_e_n = cm3;
		if (s6 == QMax) begin
			ctx_e_n.aux = QMax;
			ctx_e_n.neg = 1'b0;
		end else if (s6 >= cm3.aux) begin
			ctx_e_n.aux = s6 - cm3.aux;
			ctx_e_n.neg = 1'b0;
		end else begin
			ctx_e_n.aux = cm3.aux - s6;
			ctx_e_n.neg = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_e <= '0;
		end else if (en) begin
			ctx_e <= ctx_e_n;
		end
	end

	lpf_mulq u_mul_eps (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a({17'd0, ctx_e.eps, 16'd0}), .b(ctx_e.aux), .ctx_i(ctx_e),
		.p(m), .ctx_o(cm4)
	);

	// Scale by twelve with saturation
	always_ff @(posedge clk) begin
		if (en) begin
			num12 <= (m > M12Lim) ? QMax : (m << 3) + (m << 2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_12 <= '0;
		end else if (en) begin
			ctx_12 <= cm4;
		end
	end

	// g = 12*eps*e / r^2
	lpf_div u_div_g (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(num12), .ctx_i(ctx_12), .q(g), .ctx_o(cd2)
	);

	// Per-axis force magnitude g*|d|
	lpf_mulq u_mul_fx (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a(g), .b(64'(cd2.mag[0])), .ctx_i(cd2), .p(f[0]), .ctx_o(ctx_o)
	);

	lpf_mulq u_mul_fy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a(g), .b(64'(cd2.mag[1])), .ctx_i(cd2), .p(f[1]), .ctx_o()
	);

	lpf_mulq u_mul_fz (
		.clk(clk), .arst_n(arst_n), .en(en),
		.a(g), .b(64'(cd2.mag[2])), .ctx_i(cd2), .p(f[2]), .ctx_o()
	);

endmodule

FILE: src/lipid_pair_lj_force_core.sv
// Top level of the lipid pair Lennard-Jones force core: configuration
// registers, force accumulation and output register. Uses lpf_pkg, lpf_seq, lpf_pair.
`timescale 1ns / 1ps

// One beat on s_* carries two three-bead lipids (centre and direction of
// each); one beat on m_* carries the summed Lennard-Jones force on the head,
// middle and tail bead of the first lipid. The nine bead pairs of a beat go
// one per cycle, unless the pipeline is stalled, through a single pipelined
// pair-force unit, so the block takes a new beat only when idle or as the
// last pair of the previous beat issues. The pair unit holds two 33-stage
// dividers and several two-stage multipliers; ten beats can be in flight.
// Back-pressure on m_* stalls the whole pipeline without loss. Configure
// the registers through the APB port only while no beat is in flight.

module lipid_pair_lj_force_core import lpf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// Input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// a_pos_x, a_pos_y, a_pos_z (32 each), a_dir_x, a_dir_y, a_dir_z (18 each),
	// b_pos_x, b_pos_y, b_pos_z (32 each), b_dir_x, b_dir_y, b_dir_z (18 each)
	input  logic [303:0] s_tdata,
	// Output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// head_force_x/y/z, mid_force_x/y/z, tail_force_x/y/z (32 each)
	output logic [287:0] m_tdata
);

	cfg_t             cfg_q;
	logic             wr;
	logic             adv, done;
	ctx_t             ctx_p1, ctx_f;
	logic [2:0][63:0] f;
	logic             out_vld_q;
	logic signed [33:0] acc_q [3][3];
	logic signed [33:0] nxt   [3][3];
	logic signed [33:0] contrib [3];

	function automatic logic [31:0] sat32(input logic signed [33:0] v);
		logic [31:0] r;
		if (v > 34'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -34'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Register writes
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bead_offset    <= 31'd65536;
			cfg_q.cutoff_radius  <= 31'd163840;
			cfg_q.eps_head_head  <= 31'd65536;
			cfg_q.rmin_head_head <= 31'd65536;
			cfg_q.eps_head_tail  <= 31'd65536;
			cfg_q.rmin_head_tail <= 31'd65536;
			cfg_q.eps_tail_tail  <= 31'd65536;
			cfg_q.rmin_tail_tail <= 31'd65536;
		end else if (wr) begin
			unique case (paddr[4:2])
				RegBeadOffset: cfg_q.bead_offset    <= pwdata[30:0];
				RegCutoff:     cfg_q.cutoff_radius  <= pwdata[30:0];
				RegEpsHH:      cfg_q.eps_head_head  <= pwdata[30:0];
				RegRminHH:     cfg_q.rmin_head_head <= pwdata[30:0];
				RegEpsHT:      cfg_q.eps_head_tail  <= pwdata[30:0];
				RegRminHT:     cfg_q.rmin_head_tail <= pwdata[30:0];
				RegEpsTT:      cfg_q.eps_tail_tail  <= pwdata[30:0];
				default:       cfg_q.rmin_tail_tail <= pwdata[30:0];
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (paddr[4:2])
			RegBeadOffset: prdata = {1'b0, cfg_q.bead_offset};
			RegCutoff:     prdata = {1'b0, cfg_q.cutoff_radius};
			RegEpsHH:      prdata = {1'b0, cfg_q.eps_head_head};
			RegRminHH:     prdata = {1'b0, cfg_q.rmin_head_head};
			RegEpsHT:      prdata = {1'b0, cfg_q.eps_head_tail};
			RegRminHT:     prdata = {1'b0, cfg_q.rmin_head_tail};
			RegEpsTT:      prdata = {1'b0, cfg_q.eps_tail_tail};
			default:       prdata = {1'b0, cfg_q.rmin_tail_tail};
		endcase
	end

	// Hold the pipeline only when a finished beat cannot enter the output register
	assign done = ctx_f.vld && ctx_f.last;
	assign adv  = !(done && out_vld_q && !m_tready);

	lpf_seq u_seq (
		.clk(clk), .arst_n(arst_n), .en(adv), .cfg(cfg_q),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.ctx_o(ctx_p1)
	);

	lpf_pair u_pair (
		.clk(clk), .arst_n(arst_n), .en(adv), .cfg(cfg_q),
		.ctx_i(ctx_p1), .f(f), .ctx_o(ctx_f)
	);

	// Signed, clamped contribution of this pair per axis
	always_comb begin
		logic [63:0] fm;
		for (int ax = 0; ax < 3; ax++) begin
			fm = (f[ax] > FMax) ? FMax : f[ax];
			if (ctx_f.skip) begin
				contrib[ax] = '0;
			end else if (ctx_f.dneg[ax] != ctx_f.neg) begin
				contrib[ax] = -$signed(34'(fm[32:0]));
			end else begin
				contrib[ax] = $signed(34'(fm[32:0]));
			end
		end
		for (int b = 0; b < 3; b++) begin
			for (int ax = 0; ax < 3; ax++) begin
				nxt[b][ax] = acc_q[b][ax] +
					((ctx_f.bead == 2'(b)) ? contrib[ax] : 34'sd0);
			end
		end
	end

	// Accumulate per bead; close the beat on its last pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < 3; b++) begin
				for (int ax = 0; ax < 3; ax++) begin
					acc_q[b][ax] <= '0;
				end
			end
		end else if (adv && ctx_f.vld) begin
			for (int b = 0; b < 3; b++) begin
				for (int ax = 0; ax < 3; ax++) begin
					acc_q[b][ax] <= ctx_f.last ? 34'sd0 : nxt[b][ax];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && done) begin
			for (int b = 0; b < 3; b++) begin
				for (int ax = 0; ax < 3; ax++) begin
					m_tdata[96*b + 32*ax +: 32] <= sat32(nxt[b][ax]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && done) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;

endmodule
